[sv/rw_lock_replica_balancer_top_macros.svh]
// ----------------------------------------------------------------------------
// rw_lock_replica_balancer_top_macros
// Assertion macros shared by the lock balancer checker.
// ----------------------------------------------------------------------------
`ifndef RW_LOCK_REPLICA_BALANCER_TOP_MACROS_SVH
`define RW_LOCK_REPLICA_BALANCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RWLRB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwlrb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RWLRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwlrb assertion failed");

`endif

[sv/rwlrb_pkg.sv]
// ----------------------------------------------------------------------------
// rwlrb_pkg
// Types, codes and default sizes of the readers-writers lock balancer.
// ----------------------------------------------------------------------------
package rwlrb_pkg;

    localparam int REPLICAS_DEF = 3;
    localparam int RQ_DEPTH_DEF = 16;
    localparam int WQ_DEPTH_DEF = 4;

    localparam int ID_W        = 8;
    localparam int LOAD_W      = 8;
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = $clog2(MAX_RESULTS);

    localparam logic [LOAD_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ACT_RD_REQ  = 2'd0,
        ACT_RD_REL  = 2'd1,
        ACT_WR_REQ  = 2'd2,
        ACT_WR_DONE = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        RES_RD_GRANT = 2'd0,
        RES_WR_GRANT = 2'd1,
        RES_REFUSED  = 2'd2,
        RES_ERROR    = 2'd3
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

[sv/rw_lock_replica_balancer_top.sv]
// ----------------------------------------------------------------------------
// rw_lock_replica_balancer_top
// Writer-preferring readers-writers lock that spreads readers over replicas.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------------
//  item in   | start, busy           | action, requester_id, replica_released
//  result    | strobe (one cycle)    | event_res, granted_id, replica_assigned,
//            |                       | last
//
//  An item is taken when start is high and busy is low. Busy is high through
//  the decode state, and through a least-loaded search for each reader grant:
//  the search walks the replica loads one compare a cycle. A wake-up after
//  writer done grants up to 16 queued readers. Results are registered, in the
//  cycle after the decision that makes them; the receiver cannot stall. Reset
//  (rst_n low) empties both queues and clears all loads.
// ----------------------------------------------------------------------------
module rw_lock_replica_balancer_top
    import rwlrb_pkg::*;
#(
    parameter int REPLICAS = REPLICAS_DEF,
    parameter int RQ_DEPTH = RQ_DEPTH_DEF,
    parameter int WQ_DEPTH = WQ_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      action,
    input  logic [ID_W-1:0] requester_id,
    input  logic [1:0]      replica_released,
    output logic            strobe,
    output logic [1:0]      event_res,
    output logic [ID_W-1:0] granted_id,
    output logic [1:0]      replica_assigned,
    output logic            last
);

    localparam int IDX_W    = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH+1);
    localparam int WQ_CNT_W = $clog2(WQ_DEPTH+1);

    state_t            state_reg, state_next;
    logic [1:0]        act_reg;
    logic [ID_W-1:0]   id_reg;
    logic [1:0]        rel_reg;

    logic              wb_reg, wb_next;
    logic [LOAD_W-1:0] total_reg, total_next;
    logic [LOAD_W-1:0] load_reg [REPLICAS];
    logic [LOAD_W-1:0] load_next [REPLICAS];
    logic [N_W-1:0]    n_reg, n_next;
    logic              wake_reg, wake_next;

    logic              strobe_reg, strobe_next;
    logic [1:0]        res_reg, res_next;
    logic [ID_W-1:0]   gid_reg, gid_next;
    logic [1:0]        rep_reg, rep_next;
    logic              last_reg, last_next;

    fifo_ctl_t             rq_ctl, wq_ctl;
    logic [ID_W-1:0]       rq_rdata, wq_rdata;
    logic [RQ_CNT_W-1:0]   rq_count;
    logic [WQ_CNT_W-1:0]   wq_count;
    logic                  rq_full, rq_empty, wq_full, wq_empty;

    logic                  scan_start, scan_done;
    logic [IDX_W-1:0]      scan_addr, scan_best;

    logic                  accept;
    logic                  rel_in_range, rel_ok;
    logic [IDX_W-1:0]      rd_addr;
    logic [LOAD_W-1:0]     load_rd;
    logic                  rd_now, total_full, wake_any, more_rd;

    rwlrb_fifo #(.DEPTH(RQ_DEPTH)) u_rq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rq_ctl),
        .wdata (id_reg),
        .rdata (rq_rdata),
        .count (rq_count),
        .full  (rq_full),
        .empty (rq_empty)
    );

    rwlrb_fifo #(.DEPTH(WQ_DEPTH)) u_wq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (wq_ctl),
        .wdata (id_reg),
        .rdata (wq_rdata),
        .count (wq_count),
        .full  (wq_full),
        .empty (wq_empty)
    );

    rwlrb_scan #(.REPLICAS(REPLICAS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .load_data (load_rd),
        .addr      (scan_addr),
        .done      (scan_done),
        .best      (scan_best)
    );

    assign accept = start && (state_reg == ST_IDLE);

    // single read port on the loads: release check in decode, search otherwise
    assign rel_in_range = (32'(rel_reg) < 32'(REPLICAS));
    assign rd_addr      = (state_reg == ST_EXEC) ?
                          (rel_in_range ? IDX_W'(rel_reg) : '0) : scan_addr;
    assign load_rd      = load_reg[rd_addr];
    assign rel_ok       = rel_in_range && (load_rd != '0) && (total_reg != '0);

    assign rd_now     = !wb_reg && wq_empty;
    assign total_full = (total_reg == TOTAL_MAX);
    assign wake_any   = !rq_empty && !total_full;
    // another queued reader follows this grant, within result cap and total
    assign more_rd    = (rq_count != RQ_CNT_W'(1))
                     && (n_reg != N_W'(MAX_RESULTS-1))
                     && (total_reg != TOTAL_MAX - LOAD_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (act_t'(act_reg))
                    ACT_RD_REQ:
                    begin
                        if (rd_now && !total_full)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    ACT_WR_DONE:
                    begin
                        if (wb_reg && wq_empty && wake_any)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_done && (!wake_reg || !more_rd))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        wb_next     = wb_reg;
        total_next  = total_reg;
        load_next   = load_reg;
        n_next      = n_reg;
        wake_next   = wake_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        gid_next    = gid_reg;
        rep_next    = 2'd0;
        last_next   = 1'b1;
        rq_ctl      = '0;
        wq_ctl      = '0;
        scan_start  = 1'b0;

        case (state_reg)
            ST_EXEC:
            begin
                gid_next = id_reg;
                case (act_t'(act_reg))
                    ACT_RD_REQ:
                    begin
                        if (rd_now)
                        begin
                            if (total_full)
                            begin
                                strobe_next = 1'b1;
                                res_next    = RES_REFUSED;
                            end
                            else
                            begin
                                scan_start = 1'b1;
                                wake_next  = 1'b0;
                            end
                        end
                        else if (rq_full)
                        begin
                            strobe_next = 1'b1;
                            res_next    = RES_REFUSED;
                        end
                        else
                        begin
                            rq_ctl.push = 1'b1;
                        end
                    end
                    ACT_RD_REL:
                    begin
                        if (!rel_ok)
                        begin
                            strobe_next = 1'b1;
                            res_next    = RES_ERROR;
                        end
                        else
                        begin
                            load_next[rd_addr] = load_rd - LOAD_W'(1);
                            total_next         = total_reg - LOAD_W'(1);
                            // last reader out hands the lock to the head writer
                            if (total_reg == LOAD_W'(1) && !wq_empty && !wb_reg)
                            begin
                                strobe_next = 1'b1;
                                res_next    = RES_WR_GRANT;
                                gid_next    = wq_rdata;
                                wq_ctl.pop  = 1'b1;
                                wb_next     = 1'b1;
                            end
                        end
                    end
                    ACT_WR_REQ:
                    begin
                        if (!wb_reg && total_reg == '0)
                        begin
                            wb_next     = 1'b1;
                            strobe_next = 1'b1;
                            res_next    = RES_WR_GRANT;
                        end
                        else if (wq_full)
                        begin
                            strobe_next = 1'b1;
                            res_next    = RES_REFUSED;
                        end
                        else
                        begin
                            wq_ctl.push = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!wb_reg)
                        begin
                            strobe_next = 1'b1;
                            res_next    = RES_ERROR;
                        end
                        else if (!wq_empty)
                        begin
                            strobe_next = 1'b1;
                            res_next    = RES_WR_GRANT;
                            gid_next    = wq_rdata;
                            wq_ctl.pop  = 1'b1;
                        end
                        else
                        begin
                            wb_next = 1'b0;
                            if (wake_any)
                            begin
                                scan_start = 1'b1;
                                wake_next  = 1'b1;
                                n_next     = '0;
                            end
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    load_next[scan_best] = load_reg[scan_best] + LOAD_W'(1);
                    total_next           = total_reg + LOAD_W'(1);
                    strobe_next          = 1'b1;
                    res_next             = RES_RD_GRANT;
                    rep_next             = 2'(scan_best);
                    if (wake_reg)
                    begin
                        gid_next    = rq_rdata;
                        last_next   = !more_rd;
                        rq_ctl.pop  = 1'b1;
                        n_next      = n_reg + N_W'(1);
                        scan_start  = more_rd;
                    end
                    else
                    begin
                        gid_next = id_reg;
                    end
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wb_reg     <= 1'b0;
            total_reg  <= '0;
            n_reg      <= '0;
            wake_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < REPLICAS; i++)
            begin
                load_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            wb_reg     <= wb_next;
            total_reg  <= total_next;
            n_reg      <= n_next;
            wake_reg   <= wake_next;
            strobe_reg <= strobe_next;
            load_reg   <= load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            id_reg  <= requester_id;
            rel_reg <= replica_released;
        end
        res_reg  <= res_next;
        gid_reg  <= gid_next;
        rep_reg  <= rep_next;
        last_reg <= last_next;
    end

    assign busy             = (state_reg != ST_IDLE);
    assign strobe           = strobe_reg;
    assign event_res        = res_reg;
    assign granted_id       = gid_reg;
    assign replica_assigned = rep_reg;
    assign last             = last_reg;

endmodule

[sv/rwlrb_fifo.sv]
// ----------------------------------------------------------------------------
// rwlrb_fifo
// Wait queue of requester ids; head entry presented on a registered read port.
// ----------------------------------------------------------------------------
module rwlrb_fifo
    import rwlrb_pkg::*;
#(
    parameter int DEPTH = RQ_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fifo_ctl_t                    ctl,
    input  logic [ID_W-1:0]              wdata,
    output logic [ID_W-1:0]              rdata,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic                         full,
    output logic                         empty
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [ID_W-1:0]  mem [DEPTH];
    logic [ID_W-1:0]  rdata_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH-1))
        begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.pop)
        begin
            head_next  = wrap_inc(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (ctl.push && ctl.pop)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= wdata;
        end
        rdata_reg <= mem[head_reg];
    end

    assign rdata = rdata_reg;
    assign count = count_reg;
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

[sv/rwlrb_scan.sv]
// ----------------------------------------------------------------------------
// rwlrb_scan
// Least-loaded replica search: one compare per cycle over the load registers.
// ----------------------------------------------------------------------------
module rwlrb_scan
    import rwlrb_pkg::*;
#(
    parameter int REPLICAS = REPLICAS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  logic [LOAD_W-1:0]                               load_data,
    output logic [((REPLICAS > 1) ? $clog2(REPLICAS) : 1)-1:0] addr,
    output logic                                            done,
    output logic [((REPLICAS > 1) ? $clog2(REPLICAS) : 1)-1:0] best
);

    localparam int IDX_W = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;

    logic              run_reg;
    logic              done_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  best_reg;
    logic [LOAD_W-1:0] best_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (idx_reg == IDX_W'(REPLICAS-1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // strict less-than keeps the lowest index on a tie
    always_ff @(posedge clk)
    begin
        if (run_reg && (idx_reg == '0 || load_data < best_val_reg))
        begin
            best_reg     <= idx_reg;
            best_val_reg <= load_data;
        end
    end

    assign addr = idx_reg;
    assign done = done_reg;
    assign best = best_reg;

endmodule

[sv/rwlrb_checker.sv]
// ----------------------------------------------------------------------------
// rwlrb_checker
// Port-level checks on the lock balancer, bound to the top level.
// ----------------------------------------------------------------------------
`include "rw_lock_replica_balancer_top_macros.svh"

module rwlrb_checker
    import rwlrb_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [1:0]      action,
    input logic [ID_W-1:0] requester_id,
    input logic [1:0]      replica_released,
    input logic            strobe,
    input logic [1:0]      event_res,
    input logic [ID_W-1:0] granted_id,
    input logic [1:0]      replica_assigned,
    input logic            last
);

    // a taken item always holds the block for its decode cycle
    `RWLRB_ASSERT_NEXT(a_take_busy, start && !busy, busy)

    // only reader grants carry a replica
    `RWLRB_ASSERT_NOW(a_rep_zero, strobe && event_res != RES_RD_GRANT, replica_assigned == 2'd0)

    // refusals and errors are always the sole result of their item
    `RWLRB_ASSERT_NOW(a_single, strobe && (event_res == RES_REFUSED || event_res == RES_ERROR), last)

    // more results pending: no new item may be taken yet
    `RWLRB_ASSERT_NOW(a_burst_busy, strobe && !last, busy)

endmodule

bind rw_lock_replica_balancer_top rwlrb_checker u_rwlrb_checker (.*);

[tb/rw_lock_replica_balancer_top_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rw_lock_replica_balancer_top_checker
// Watches the item and result channels of the lock balancer. It keeps its own
// copy of the lock state (writer flag, reader total, replica loads and both
// wait lines) and predicts the grants, refusals and errors of every accepted
// item. Each strobed result is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module rw_lock_replica_balancer_top_checker
    import rwlrb_pkg::*;
#(
    parameter int NREP   = REPLICAS_DEF,
    parameter int RQ_CAP = RQ_DEPTH_DEF,
    parameter int WQ_CAP = WQ_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [1:0]      action,
    input  logic [ID_W-1:0] requester_id,
    input  logic [1:0]      replica_released,
    input  logic            strobe,
    input  logic [1:0]      event_res,
    input  logic [ID_W-1:0] granted_id,
    input  logic [1:0]      replica_assigned,
    input  logic            last,
    output int              mismatches,
    output int              pending,
    output int              items_seen,
    output int              results_seen
);

    typedef struct packed {
        res_t            kind;
        logic [ID_W-1:0] id;
        logic [1:0]      rep;
        logic            fin;
    } lock_result_t;

    lock_result_t      grant_expect[$];
    logic [ID_W-1:0]   reader_line[$];
    logic [ID_W-1:0]   writer_line[$];
    logic              writer_held;
    logic [LOAD_W-1:0] readers_held;
    logic [LOAD_W-1:0] load [NREP];
    int                fail_count;
    int                item_count;
    int                result_count;
    int                noted;

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, result_count, what, got, want);
    endtask

    function automatic int lightest_replica();
        int pick;
        pick = 0;
        for (int i = 1; i < NREP; i++)
            if (load[i] < load[pick])
                pick = i;
        return pick;
    endfunction

    task automatic note_result(res_t kind, logic [ID_W-1:0] id, logic [1:0] rep);
        grant_expect.push_back('{kind, id, rep, 1'b0});
        noted++;
    endtask

    task automatic grant_to_reader(logic [ID_W-1:0] id);
        int r;
        r = lightest_replica();
        load[r]++;
        readers_held++;
        note_result(RES_RD_GRANT, id, 2'(r));
    endtask

    task automatic grant_waiting_writer();
        logic [ID_W-1:0] id;
        id = writer_line.pop_front();
        writer_held = 1'b1;
        note_result(RES_WR_GRANT, id, 2'd0);
    endtask

    task automatic apply_event(act_t act, logic [ID_W-1:0] id, logic [1:0] rel);
        lock_result_t tail;
        noted = 0;
        case (act)
            ACT_RD_REQ:
                if (!writer_held && writer_line.size() == 0)
                begin
                    if (readers_held == TOTAL_MAX)
                        note_result(RES_REFUSED, id, 2'd0);
                    else
                        grant_to_reader(id);
                end
                else if (reader_line.size() >= RQ_CAP)
                    note_result(RES_REFUSED, id, 2'd0);
                else
                    reader_line.push_back(id);
            ACT_RD_REL:
                if (int'(rel) >= NREP)
                    note_result(RES_ERROR, id, 2'd0);
                else if (load[rel] == 0 || readers_held == 0)
                    note_result(RES_ERROR, id, 2'd0);
                else
                begin
                    load[rel]--;
                    readers_held--;
                    // last reader out hands the lock to the head writer
                    if (readers_held == 0 && writer_line.size() > 0 && !writer_held)
                        grant_waiting_writer();
                end
            ACT_WR_REQ:
                if (!writer_held && readers_held == 0)
                begin
                    writer_held = 1'b1;
                    note_result(RES_WR_GRANT, id, 2'd0);
                end
                else if (writer_line.size() >= WQ_CAP)
                    note_result(RES_REFUSED, id, 2'd0);
                else
                    writer_line.push_back(id);
            default:
                if (!writer_held)
                    note_result(RES_ERROR, id, 2'd0);
                else
                begin
                    writer_held = 1'b0;
                    if (writer_line.size() > 0)
                        grant_waiting_writer();
                    else
                        // wake queued readers, capped per item
                        while (reader_line.size() > 0 && noted < MAX_RESULTS &&
                               readers_held != TOTAL_MAX)
                            grant_to_reader(reader_line.pop_front());
                end
        endcase
        if (noted > 0)
        begin
            tail = grant_expect.pop_back();
            tail.fin = 1'b1;
            grant_expect.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lock_result_t want;
        if (!rst_n)
        begin
            grant_expect.delete();
            reader_line.delete();
            writer_line.delete();
            writer_held = 1'b0;
            readers_held = '0;
            foreach (load[i])
                load[i] = '0;
            fail_count = 0;
            item_count = 0;
            result_count = 0;
            mismatches <= 0;
            pending <= 0;
            items_seen <= 0;
            results_seen <= 0;
        end
        else
        begin
            // results here belong to items taken at earlier edges
            if (strobe)
            begin
                result_count++;
                if (grant_expect.size() == 0)
                    report_mismatch("unexpected result, event_res", event_res, -1);
                else
                begin
                    want = grant_expect.pop_front();
                    if (event_res !== want.kind)
                        report_mismatch("event_res", event_res, want.kind);
                    if (granted_id !== want.id)
                        report_mismatch("granted_id", granted_id, want.id);
                    if (replica_assigned !== want.rep)
                        report_mismatch("replica_assigned", replica_assigned, want.rep);
                    if (last !== want.fin)
                        report_mismatch("last", last, want.fin);
                end
            end
            if (start && !busy)
            begin
                item_count++;
                apply_event(act_t'(action), requester_id, replica_released);
            end
            mismatches <= fail_count;
            pending <= grant_expect.size();
            items_seen <= item_count;
            results_seen <= result_count;
        end
    end

endmodule

[tb/rw_lock_replica_balancer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rw_lock_replica_balancer_top_tb
// Drives lock events into the balancer: a directed opening over every action
// and corner that also fills the writer line, a limits phase that fills the
// reader line, wakes it in full and saturates the reader total, then random
// traffic shaped by a view of the readers and writer currently holding the
// lock. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rw_lock_replica_balancer_top_tb
    import rwlrb_pkg::*;
();

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_WAIT   = 2000;
    localparam int SETTLE       = 80;
    localparam int RANDOM_ITEMS = 310;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      action;
    logic [ID_W-1:0] requester_id;
    logic [1:0]      replica_released;
    logic            strobe;
    logic [1:0]      event_res;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      replica_assigned;
    logic            last;

    int         mismatches;
    int         pending;
    int         items_seen;
    int         results_seen;
    int         cycles = 0;
    logic [1:0] held_replicas[$];
    logic       writer_on = 1'b0;
    logic       no_gaps = 1'b0;

    rw_lock_replica_balancer_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .requester_id     (requester_id),
        .replica_released (replica_released),
        .strobe           (strobe),
        .event_res        (event_res),
        .granted_id       (granted_id),
        .replica_assigned (replica_assigned),
        .last             (last)
    );

    rw_lock_replica_balancer_top_checker u_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .requester_id     (requester_id),
        .replica_released (replica_released),
        .strobe           (strobe),
        .event_res        (event_res),
        .granted_id       (granted_id),
        .replica_assigned (replica_assigned),
        .last             (last),
        .mismatches       (mismatches),
        .pending          (pending),
        .items_seen       (items_seen),
        .results_seen     (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("rw_lock_replica_balancer_top verification failed");
            $finish;
        end
    end

    // track who holds the lock, only to shape releases and writer done
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (event_res == RES_RD_GRANT)
                held_replicas.push_back(replica_assigned);
            else if (event_res == RES_WR_GRANT)
                writer_on = 1'b1;
        end
    end

    task automatic send_item(act_t act, logic [ID_W-1:0] id, logic [1:0] rel);
        start <= 1'b1;
        action <= act;
        requester_id <= id;
        replica_released <= rel;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(99);
        if (no_gaps || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_gapped(act_t act, logic [ID_W-1:0] id, logic [1:0] rel);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_item(act, id, rel);
    endtask

    // hold off until every predicted result has arrived and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
    endtask

    task automatic release_held();
        int k;
        logic [1:0] rel;
        if (held_replicas.size() > 0)
        begin
            k = $urandom_range(held_replicas.size() - 1);
            rel = held_replicas[k];
            held_replicas.delete(k);
        end
        else
            rel = 2'($urandom_range(3));
        send_gapped(ACT_RD_REL, 8'($urandom_range(255)), rel);
    endtask

    initial
    begin
        int              roll;
        int              rd_cut;
        int              wait_left;
        act_t            act;
        logic [ID_W-1:0] id;
        logic [1:0]      rel;

        rst_n <= 1'b0;
        start <= 1'b0;
        action <= ACT_RD_REQ;
        requester_id <= '0;
        replica_released <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        send_gapped(ACT_RD_REQ, 8'h00, 2'd0);
        send_gapped(ACT_RD_REQ, 8'hFF, 2'd3);
        send_gapped(ACT_RD_REQ, 8'h5A, 2'd2);
        send_gapped(ACT_RD_REL, 8'h01, 2'd3);   // replica out of range
        send_gapped(ACT_WR_REQ, 8'hAA, 2'd1);   // queue behind readers
        send_gapped(ACT_RD_REQ, 8'h11, 2'd0);   // queue behind waiting writer
        send_gapped(ACT_RD_REL, 8'h02, 2'd0);
        send_gapped(ACT_RD_REL, 8'h03, 2'd0);   // replica already empty
        send_gapped(ACT_RD_REL, 8'h04, 2'd1);
        send_gapped(ACT_RD_REL, 8'h05, 2'd2);   // last reader out, writer in
        for (int w = 0; w < 5; w++)
            send_gapped(ACT_WR_REQ, 8'(8'h80 + w), 2'(w));  // fifth finds line full
        for (int w = 0; w < 5; w++)
            send_gapped(ACT_WR_DONE, 8'(8'hC0 + w), 2'd0);  // last one wakes the reader
        send_gapped(ACT_WR_DONE, 8'hEE, 2'd3);  // no writer holds the lock
        send_gapped(ACT_RD_REL, 8'h06, 2'd0);
        send_gapped(ACT_WR_REQ, 8'hFF, 2'd2);
        send_gapped(ACT_RD_REL, 8'h07, 2'd1);   // nothing held
        drain();
        held_replicas.delete();

        // fill the reader line behind the writer, one more is refused
        for (int r = 0; r < RQ_DEPTH_DEF + 1; r++)
            send_gapped(ACT_RD_REQ, 8'($urandom_range(255)), 2'($urandom_range(3)));
        writer_on = 1'b0;
        send_gapped(ACT_WR_DONE, 8'h3C, 2'd0);  // wakes a full line at once
        drain();
        while (held_replicas.size() > 0)
            release_held();

        // saturate the reader total
        for (int r = 0; r < 257; r++)
            send_gapped(ACT_RD_REQ, 8'($urandom_range(255)), 2'($urandom_range(3)));
        send_gapped(ACT_WR_REQ, 8'h42, 2'd0);
        send_gapped(ACT_RD_REQ, 8'h24, 2'd1);
        drain();
        while (held_replicas.size() > 0)
            release_held();
        drain();
        writer_on = 1'b0;
        send_gapped(ACT_WR_DONE, 8'h42, 2'd0);

        // random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                no_gaps = ($urandom_range(3) == 0);
            if (n % 60 == 59)
                drain();
            roll = $urandom_range(99);
            id = 8'($urandom_range(255));
            rel = 2'($urandom_range(3));
            rd_cut = (held_replicas.size() > 6) ? 20 : 40;
            if (roll < rd_cut)
                send_gapped(ACT_RD_REQ, id, rel);
            else if (roll < 68)
            begin
                if (held_replicas.size() > 0 && $urandom_range(9) != 0)
                    release_held();
                else
                    send_gapped(ACT_RD_REL, id, rel);
            end
            else
            begin
                act = ACT_WR_REQ;
                if (roll >= 82 && (writer_on || $urandom_range(4) == 0))
                begin
                    act = ACT_WR_DONE;
                    writer_on = 1'b0;
                end
                send_gapped(act, id, rel);
            end
        end

        start <= 1'b0;
        wait_left = 0;
        @(posedge clk);
        while ((pending != 0 || busy) && wait_left < DRAIN_WAIT)
        begin
            @(posedge clk);
            wait_left++;
        end
        repeat (SETTLE) @(posedge clk);

        $display("Summary: %0d lock events taken, %0d results checked",
                 items_seen, results_seen);
        $display("Covered both wait lines full, a full reader wake-up, reader total at 255");
        if (mismatches == 0 && pending == 0)
            $display("rw_lock_replica_balancer_top verification clean");
        else
            $display("rw_lock_replica_balancer_top verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rwlrb_pkg.sv
sv/rwlrb_fifo.sv
sv/rwlrb_scan.sv
sv/rw_lock_replica_balancer_top.sv
sv/rwlrb_checker.sv
tb/rw_lock_replica_balancer_top_checker.sv
tb/rw_lock_replica_balancer_top_tb.sv
